// File: rtl/core/qch_pkg.sv
// ----------------------------------------------------------------------------
// qch_pkg: shared types and constants for the quaternion compass heading block
// Fixed-point formats, the CORDIC angle table in degrees and the vector type
// carried down the rotation pipeline.
// ----------------------------------------------------------------------------
package qch_pkg;

  // Default rotation stage count
  localparam int QCH_CORDIC_STAGES = 24;

  // Quaternion component, signed Q2.30
  localparam int QUAT_W = 32;
  typedef logic signed [QUAT_W-1:0] quat_t;

  // Compass heading, degrees times 65536
  localparam int HEAD_W = 25;
  typedef logic [HEAD_W-1:0] heading_t;

  // Products and vector components, 64-bit signed
  localparam int VEC_W = 64;
  typedef logic signed [VEC_W-1:0] vec_t;

  // Angle in degrees times 2^24; magnitude stays below 2^33
  localparam int ANG_W = 35;
  typedef logic signed [ANG_W-1:0] ang_t;

  // 2.0 in the scaled vector format (Q7.57: Q4.60 products scaled by 1/8)
  localparam vec_t HALF_UNIT = 64'sh0400_0000_0000_0000;

  localparam ang_t DEG90  = 35'sd1509949440;
  localparam ang_t DEG180 = 35'sd3019898880;
  localparam ang_t DEG360 = 35'sd6039797760;

  // atan(2^-i) in degrees times 2^24, rounded to nearest
  localparam ang_t ATAN_TAB [32] = '{
    35'sd754974720, 35'sd445687602, 35'sd235489088, 35'sd119537938,
    35'sd60000934,  35'sd30029717,  35'sd15018523,  35'sd7509720,
    35'sd3754917,   35'sd1877466,   35'sd938734,    35'sd469367,
    35'sd234684,    35'sd117342,    35'sd58671,     35'sd29335,
    35'sd14668,     35'sd7334,      35'sd3667,      35'sd1833,
    35'sd917,       35'sd458,       35'sd229,       35'sd115,
    35'sd57,        35'sd29,        35'sd14,        35'sd7,
    35'sd4,         35'sd2,         35'sd1,         35'sd0
  };

  // Vector and accumulated angle between rotation stages
  typedef struct packed {
    vec_t x;
    vec_t y;
    ang_t ang;
    logic zero;
  } cord_t;

endpackage

// File: rtl/core/qch_in_if.sv
// ----------------------------------------------------------------------------
// qch_in_if: quaternion input channel
// Valid/ready handshake carrying one attitude quaternion per transaction.
// ----------------------------------------------------------------------------
interface qch_in_if;
  import qch_pkg::*;

  logic  valid;
  logic  ready;
  quat_t quat_x;
  quat_t quat_y;
  quat_t quat_z;
  quat_t quat_w;

  modport source (output valid, output quat_x, output quat_y, output quat_z,
                  output quat_w, input ready);
  modport sink   (input valid, input quat_x, input quat_y, input quat_z,
                  input quat_w, output ready);
endinterface

// File: rtl/core/qch_out_if.sv
// ----------------------------------------------------------------------------
// qch_out_if: compass heading result channel
// Valid/ready handshake carrying one heading per transaction.
// ----------------------------------------------------------------------------
interface qch_out_if;
  import qch_pkg::*;

  logic     valid;
  logic     ready;
  heading_t heading;

  modport source (output valid, output heading, input ready);
  modport sink   (input valid, input heading, output ready);
endinterface

// File: rtl/core/qch_cordic_stage.sv
// ----------------------------------------------------------------------------
// qch_cordic_stage: one registered vectoring CORDIC micro-rotation
// Rotates the vector toward the x axis by atan(2^-IDX) and updates the angle.
// ----------------------------------------------------------------------------
module qch_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          v_in,
  input  qch_pkg::cord_t d,
  output logic          v_r,
  output qch_pkg::cord_t q_r
);
  import qch_pkg::*;

  localparam ang_t STEP = ATAN_TAB[IDX % 32];

  cord_t q_nxt;
  vec_t  dx;
  vec_t  dy;

  // Rotate using the old x and y, shifts round toward minus infinity
  always_comb begin
    dx = d.y >>> IDX;
    dy = d.x >>> IDX;
    q_nxt.zero = d.zero;
    if (d.y > 0) begin
      q_nxt.x   = d.x + dx;
      q_nxt.y   = d.y - dy;
      q_nxt.ang = d.ang + STEP;
    end else begin
      q_nxt.x   = d.x - dx;
      q_nxt.y   = d.y + dy;
      q_nxt.ang = d.ang - STEP;
    end
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

// File: rtl/core/quaternion_to_compass_heading.sv
// ----------------------------------------------------------------------------
// quaternion_to_compass_heading: attitude quaternion to compass heading
// Forms the ENU yaw with a pipelined CORDIC and gives the heading 90 - yaw,
// wrapped into [0, 360) degrees, as degrees times 65536.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one quaternion (quat_x, quat_y, quat_z, quat_w, signed Q2.30) per
//            transaction, valid/ready.
//   out_if : one heading per input, 0 = North, clockwise, degrees * 65536.
//   Pipeline: a transaction passes CORDIC_STAGES + 4 registers: product
//   stage, vector sum stage, pre-rotation stage, one stage per CORDIC
//   micro-rotation and the wrap/output register.
//   Throughput is one transaction per cycle while the receiver keeps
//   ready high; every stage is a registered copy of its own arithmetic,
//   so nothing is shared between items.
//   Reset clears every stage valid bit; payload registers are not reset.
//   When the receiver stalls, the output stage holds its result and each
//   stage holds only if the one below it is full, so empty slots close up.
//   in_if.ready drops only once every stage holds a transaction.
//   A zero vector (atan2(0,0)) gives a heading of exactly 90 degrees.
// ----------------------------------------------------------------------------
module quaternion_to_compass_heading #(
  parameter int CORDIC_STAGES = qch_pkg::QCH_CORDIC_STAGES
) (
  input  logic            clk,
  input  logic            rst_n,
  qch_in_if.sink          in_if,
  qch_out_if.source       out_if
);
  import qch_pkg::*;

  // Products, sums, pre-rotation, CORDIC stages, output
  localparam int NS     = CORDIC_STAGES + 4;
  localparam int S_PROD = 0;
  localparam int S_SUM  = 1;
  localparam int S_PRE  = 2;
  localparam int S_OUT  = NS - 1;

  logic [NS-1:0] v;
  logic [NS:0]   en;

  // Advance a stage when it is empty or the next one advances
  assign en[NS] = out_if.ready;
  for (genvar j = 0; j < NS; j++) begin : g_en
    assign en[j] = ~v[j] | en[j+1];
  end

  assign in_if.ready = en[0];

  // --------------------------------------------------------------------------
  // Products, full width
  // --------------------------------------------------------------------------
  vec_t wz_r, xy_r, yy_r, zz_r;
  vec_t wz_nxt, xy_nxt, yy_nxt, zz_nxt;
  logic prod_v_r;

  assign wz_nxt = vec_t'(in_if.quat_w) * vec_t'(in_if.quat_z);
  assign xy_nxt = vec_t'(in_if.quat_x) * vec_t'(in_if.quat_y);
  assign yy_nxt = vec_t'(in_if.quat_y) * vec_t'(in_if.quat_y);
  assign zz_nxt = vec_t'(in_if.quat_z) * vec_t'(in_if.quat_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else if (en[S_PROD]) begin
      prod_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_PROD]) begin
      wz_r <= wz_nxt;
      xy_r <= xy_nxt;
      yy_r <= yy_nxt;
      zz_r <= zz_nxt;
    end
  end

  assign v[S_PROD] = prod_v_r;

  // --------------------------------------------------------------------------
  // Vector: Y = 2(wz+xy)/8, X = (2 - 2(y^2+z^2))/8
  // --------------------------------------------------------------------------
  vec_t vy_r, vx_r, vy_nxt, vx_nxt;
  logic sum_v_r;

  assign vy_nxt = (wz_r >>> 2) + (xy_r >>> 2);
  assign vx_nxt = HALF_UNIT - (yy_r >>> 2) - (zz_r >>> 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_v_r <= 1'b0;
    end else if (en[S_SUM]) begin
      sum_v_r <= prod_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_SUM]) begin
      vy_r <= vy_nxt;
      vx_r <= vx_nxt;
    end
  end

  assign v[S_SUM] = sum_v_r;

  // --------------------------------------------------------------------------
  // Pre-rotation into the right half plane, flag the zero vector
  // --------------------------------------------------------------------------
  cord_t cd [0:CORDIC_STAGES];
  cord_t pre_r;
  cord_t pre_nxt;
  logic  pre_v_r;

  always_comb begin
    pre_nxt.zero = (vx_r == '0) && (vy_r == '0);
    if (vx_r < 0) begin
      pre_nxt.x   = -vx_r;
      pre_nxt.y   = -vy_r;
      pre_nxt.ang = (vy_r >= 0) ? DEG180 : -DEG180;
    end else begin
      pre_nxt.x   = vx_r;
      pre_nxt.y   = vy_r;
      pre_nxt.ang = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r <= 1'b0;
    end else if (en[S_PRE]) begin
      pre_v_r <= sum_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_PRE]) begin
      pre_r <= pre_nxt;
    end
  end

  assign cd[0]    = pre_r;
  assign v[S_PRE] = pre_v_r;

  // --------------------------------------------------------------------------
  // CORDIC micro-rotations, one register stage each
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    qch_cordic_stage #(
      .IDX (k)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en[S_PRE+1+k]),
      .v_in  (v[S_PRE+k]),
      .d     (cd[k]),
      .v_r   (v[S_PRE+1+k]),
      .q_r   (cd[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Heading = 90 - yaw, wrapped into [0, 360), drop 8 fraction bits
  // --------------------------------------------------------------------------
  cord_t    fin;
  ang_t     yaw;
  ang_t     h_raw;
  ang_t     h_wrap;
  heading_t heading_r;
  heading_t heading_nxt;
  logic     out_v_r;

  assign fin = cd[CORDIC_STAGES];

  always_comb begin
    yaw   = fin.zero ? '0 : fin.ang;
    h_raw = DEG90 - yaw;
    if (h_raw < 0) begin
      h_wrap = h_raw + DEG360;
    end else if (h_raw >= DEG360) begin
      h_wrap = h_raw - DEG360;
    end else begin
      h_wrap = h_raw;
    end
    heading_nxt = h_wrap[HEAD_W+7:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en[S_OUT]) begin
      out_v_r <= v[S_OUT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      heading_r <= heading_nxt;
    end
  end

  assign v[S_OUT]       = out_v_r;
  assign out_if.valid   = out_v_r;
  assign out_if.heading = heading_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // Input backpressure only when the whole pipe is full and the output stalls
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (&v) && !out_if.ready)
    else $error("input stalled while a pipeline slot is free");

  // Wrapped heading stays below 360 degrees
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.heading < 25'd23592960))
    else $error("heading out of range");

  // Pre-rotated vector lies in the right half plane
  a_pre_half_plane: assert property (@(posedge clk) disable iff (!rst_n)
    v[S_PRE] |-> (cd[0].x >= 0))
    else $error("pre-rotation left a negative x");

  // A held slot keeps its transaction
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (v[S_PRE] && !en[S_PRE]) |=> v[S_PRE])
    else $error("stalled transaction dropped from pre-rotation stage");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the quaternion to compass heading block
// Drives attitude quaternions over the input channel with random gaps and
// checks every heading against a bit-exact fixed-point CORDIC predictor. A
// directed table (extremes, zero vectors, pre-rotation quadrants, heading
// wrap) comes first, then random unit, yaw-only, near-zero-vector,
// tiny-component and raw 32-bit quaternions under random backpressure,
// including one long output hold-off and one full drain.
// ----------------------------------------------------------------------------
module tb_top;
  import qch_pkg::*;

  localparam int ROT_STAGES   = QCH_CORDIC_STAGES;
  localparam int DIR_ROWS     = 23;
  localparam int RAND_ITEMS   = 1280;
  localparam int FILL_AT      = 300;
  localparam int FILL_LEN     = 200;
  localparam int PAUSE_AT     = 700;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = ROT_STAGES + 20;
  localparam int STALL_LIMIT  = 2000;

  // Fixed-point constants: angles in degrees * 2^24, vector 2.0 scaled by 1/8
  localparam longint ANG_DEG90  = 64'sd1509949440;
  localparam longint ANG_DEG180 = 64'sd3019898880;
  localparam longint ANG_DEG360 = 64'sd6039797760;
  localparam longint VEC_ONE    = 64'sh0400_0000_0000_0000;

  // Quaternion component values, Q2.30
  localparam quat_t Q_ONE  = 32'sh4000_0000;
  localparam quat_t Q_NEG1 = 32'shC000_0000;
  localparam quat_t Q_MIN  = 32'sh8000_0000;
  localparam quat_t Q_MAX  = 32'sh7FFF_FFFF;
  localparam quat_t Q_R2   = 32'sd759250125;
  localparam quat_t Q_BIG  = 32'sd900000000;
  localparam quat_t Q_SML  = 32'sd300000000;

  // Heading of a zero vector: yaw 0, so due East
  localparam heading_t HEADING_EAST = 25'd5898240;

  typedef struct {
    quat_t    x;
    quat_t    y;
    quat_t    z;
    quat_t    w;
    bit       known;
    heading_t heading;
  } dir_row_t;

  typedef struct {
    quat_t    x;
    quat_t    y;
    quat_t    z;
    quat_t    w;
    heading_t heading;
  } heading_exp_t;

  logic clk;
  logic rst_n;

  qch_in_if  in_ch ();
  qch_out_if out_ch ();

  quaternion_to_compass_heading #(
    .CORDIC_STAGES (ROT_STAGES)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  heading_exp_t pending_headings [$];

  int  mismatches      = 0;
  int  quats_sent      = 0;
  int  headings_seen   = 0;
  int  idle_cycles     = 0;
  int  yaw_only_sent   = 0;
  int  near_zero_sent  = 0;
  int  raw_sent        = 0;
  bit  send_bursty     = 0;
  bit  recv_bursty     = 0;
  bit  fill_test       = 0;
  bit  hold_done       = 0;

  // Directed rows: heading typed in only for exact zero vectors
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{32'sd0, 32'sd0,  32'sd0,  Q_ONE,  1'b0, 25'd0},
    '{32'sd0, 32'sd0,  32'sd0,  Q_NEG1, 1'b0, 25'd0},
    '{32'sd0, 32'sd0,  Q_ONE,   32'sd0, 1'b1, HEADING_EAST},
    '{32'sd0, Q_ONE,   32'sd0,  32'sd0, 1'b1, HEADING_EAST},
    '{Q_MIN,  32'sd0,  Q_NEG1,  32'sd0, 1'b1, HEADING_EAST},
    '{32'sd0, Q_NEG1,  32'sd0,  Q_MIN,  1'b1, HEADING_EAST},
    '{32'sd0, 32'sd0,  Q_R2,    Q_R2,   1'b0, 25'd0},
    '{32'sd0, 32'sd0,  -Q_R2,   Q_R2,   1'b0, 25'd0},
    '{32'sd0, Q_MIN,   32'sd0,  32'sd0, 1'b0, 25'd0},
    '{32'sd0, 32'sd0,  Q_BIG,   Q_SML,  1'b0, 25'd0},
    '{32'sd0, 32'sd0,  Q_BIG,   -Q_SML, 1'b0, 25'd0},
    '{Q_MIN,  Q_MIN,   Q_MIN,   Q_MIN,  1'b0, 25'd0},
    '{Q_MAX,  Q_MAX,   Q_MAX,   Q_MAX,  1'b0, 25'd0},
    '{Q_ONE,  Q_ONE,   Q_ONE,   Q_ONE,  1'b0, 25'd0},
    '{Q_NEG1, Q_NEG1,  Q_NEG1,  Q_NEG1, 1'b0, 25'd0},
    '{Q_MAX,  Q_MIN,   Q_MAX,   Q_MIN,  1'b0, 25'd0},
    '{Q_MIN,  Q_MAX,   Q_MIN,   Q_MAX,  1'b0, 25'd0},
    '{32'sd0, 32'sd0,  32'sd0,  32'sd0, 1'b0, 25'd0},
    '{-32'sd1, -32'sd1, -32'sd1, -32'sd1, 1'b0, 25'd0},
    '{32'sd1, 32'sd1,  32'sd1,  32'sd1, 1'b0, 25'd0},
    '{32'sd0, 32'sd0,  Q_R2 + 32'sd1, Q_R2, 1'b0, 25'd0},
    '{32'sd0, 32'sd0,  Q_R2,    Q_R2 + 32'sd1, 1'b0, 25'd0},
    '{Q_ONE,  32'sd0,  32'sd0,  32'sd0, 1'b0, 25'd0}
  };

  // atan(2^-i) in degrees * 2^24, rounded to nearest
  function automatic longint atan_step_deg(int idx);
    case (idx & 31)
      0:  return 754974720;
      1:  return 445687602;
      2:  return 235489088;
      3:  return 119537938;
      4:  return 60000934;
      5:  return 30029717;
      6:  return 15018523;
      7:  return 7509720;
      8:  return 3754917;
      9:  return 1877466;
      10: return 938734;
      11: return 469367;
      12: return 234684;
      13: return 117342;
      14: return 58671;
      15: return 29335;
      16: return 14668;
      17: return 7334;
      18: return 3667;
      19: return 1833;
      20: return 917;
      21: return 458;
      22: return 229;
      23: return 115;
      24: return 57;
      25: return 29;
      26: return 14;
      27: return 7;
      28: return 4;
      29: return 2;
      30: return 1;
      default: return 0;
    endcase
  endfunction

  // Compass heading of one quaternion, bit-exact fixed point
  function automatic heading_t compass_heading(quat_t qx, quat_t qy, quat_t qz, quat_t qw);
    longint ax, ay, az, aw;
    longint vx, vy, dx, dy, yaw, h;
    int     i;
    int     sh;
    ax = qx;
    ay = qy;
    az = qz;
    aw = qw;
    vy = ((aw * az) >>> 2) + ((ax * ay) >>> 2);
    vx = VEC_ONE - ((ay * ay) >>> 2) - ((az * az) >>> 2);
    yaw = 0;
    if (vx != 0 || vy != 0) begin
      // fold the left half-plane onto the right one
      if (vx < 0) begin
        yaw = (vy >= 0) ? ANG_DEG180 : -ANG_DEG180;
        vx  = -vx;
        vy  = -vy;
      end
      for (i = 0; i < ROT_STAGES; i++) begin
        sh = i & 31;
        dx = vy >>> sh;
        dy = vx >>> sh;
        if (vy > 0) begin
          vx  = vx + dx;
          vy  = vy - dy;
          yaw = yaw + atan_step_deg(sh);
        end else begin
          vx  = vx - dx;
          vy  = vy + dy;
          yaw = yaw - atan_step_deg(sh);
        end
      end
    end
    h = ANG_DEG90 - yaw;
    if (h < 0)
      h = h + ANG_DEG360;
    if (h >= ANG_DEG360)
      h = h - ANG_DEG360;
    return heading_t'(h >>> 8);
  endfunction

  // Scale one real component of a normalized vector to Q2.30
  function automatic quat_t to_q230(real c, real norm);
    return quat_t'($rtoi(c / norm * 1073741824.0));
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Offer one quaternion, hold it until accepted, log its expected heading
  task automatic offer_quat(quat_t x, quat_t y, quat_t z, quat_t w, bit known,
                            heading_t typed);
    int           gap;
    heading_exp_t e;
    gap = send_bursty ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.quat_x <= x;
    in_ch.quat_y <= y;
    in_ch.quat_z <= z;
    in_ch.quat_w <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    e.x = x;
    e.y = y;
    e.z = z;
    e.w = w;
    e.heading = known ? typed : compass_heading(x, y, z, w);
    pending_headings.insert(pending_headings.size(), e);
    quats_sent++;
    @(negedge clk);
  endtask

  // Clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Check each heading transaction against the oldest expectation
  always @(posedge clk) begin
    heading_exp_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      headings_seen++;
      if (pending_headings.size() == 0) begin
        report_mismatch($sformatf("unexpected heading %0d", out_ch.heading));
      end else begin
        e = pending_headings.pop_front();
        if (out_ch.heading !== e.heading)
          report_mismatch($sformatf("q=(%0d,%0d,%0d,%0d) heading %0d, want %0d",
                                    e.x, e.y, e.z, e.w, out_ch.heading, e.heading));
      end
    end
  end

  // Watchdog: stop when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d headings outstanding",
               STALL_LIMIT, pending_headings.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stalls, bursts of steady ready, one long hold-off
  initial begin
    int stall;
    int taken;
    out_ch.ready = 1'b0;
    taken = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (taken % 50 == 0)
        recv_bursty = ($urandom_range(0, 2) == 0);
      stall = recv_bursty ? 0 : $urandom_range(0, 14);
      if (fill_test && !hold_done) begin
        stall     = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  // Stimulus
  initial begin
    real  rx, ry, rz, rw, norm;
    int   pick;
    int   n;
    quat_t x, y, z, w;

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.quat_x = '0;
    in_ch.quat_y = '0;
    in_ch.quat_z = '0;
    in_ch.quat_w = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    for (n = 0; n < DIR_ROWS; n++) begin
      if (n % 8 == 0)
        send_bursty = ($urandom_range(0, 1) == 0);
      offer_quat(dir_rows[n].x, dir_rows[n].y, dir_rows[n].z, dir_rows[n].w,
                 dir_rows[n].known, dir_rows[n].heading);
    end

    // Random quaternions
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n % 50 == 0)
        send_bursty = ($urandom_range(0, 2) == 0);
      if (n == FILL_AT)
        fill_test = 1'b1;
      if (n >= FILL_AT && n < FILL_AT + FILL_LEN)
        send_bursty = 1'b1;
      // drain everything before going on
      if (n == PAUSE_AT) begin
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (pending_headings.size() != 0);
      end

      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // unit quaternion, random attitude
        rx = $itor($signed($urandom));
        ry = $itor($signed($urandom));
        rz = $itor($signed($urandom));
        rw = $itor($signed($urandom));
        norm = $sqrt(rx * rx + ry * ry + rz * rz + rw * rw);
        if (norm < 1.0) begin
          x = 0; y = 0; z = 0; w = Q_ONE;
        end else begin
          x = to_q230(rx, norm);
          y = to_q230(ry, norm);
          z = to_q230(rz, norm);
          w = to_q230(rw, norm);
        end
      end else if (pick < 72) begin
        // pure yaw rotation: sweeps the whole circle and the wrap at North
        rz = $itor($signed($urandom));
        rw = $itor($signed($urandom));
        norm = $sqrt(rz * rz + rw * rw);
        x = 0;
        y = 0;
        if (norm < 1.0) begin
          z = 0; w = Q_ONE;
        end else begin
          z = to_q230(rz, norm);
          w = to_q230(rw, norm);
        end
        yaw_only_sent++;
      end else if (pick < 80) begin
        // exact or nearly zero vector
        near_zero_sent++;
        if ($urandom_range(0, 1) == 0) begin
          x = 0;
          y = $urandom_range(0, 1) ? Q_ONE : Q_NEG1;
          z = 0;
          w = quat_t'($urandom);
        end else begin
          x = quat_t'($urandom);
          y = 0;
          z = $urandom_range(0, 1) ? Q_ONE : Q_NEG1;
          w = quat_t'($signed($urandom_range(0, 6)) - 3);
        end
      end else if (pick < 87) begin
        // tiny components
        x = quat_t'($signed($urandom_range(0, 511)) - 256);
        y = quat_t'($signed($urandom_range(0, 511)) - 256);
        z = quat_t'($signed($urandom_range(0, 511)) - 256);
        w = quat_t'($signed($urandom_range(0, 511)) - 256);
      end else begin
        // raw bit patterns, far outside the unit sphere
        x = quat_t'($urandom);
        y = quat_t'($urandom);
        z = quat_t'($urandom);
        w = quat_t'($urandom);
        raw_sent++;
      end
      offer_quat(x, y, z, w, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    // Wait for the pipeline to empty, then watch for stray results
    while (pending_headings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d quaternions (%0d directed), checked %0d headings",
             quats_sent, DIR_ROWS, headings_seen);
    $display("Covered %0d yaw-only, %0d near-zero-vector and %0d raw-pattern items, %s",
             yaw_only_sent, near_zero_sent, raw_sent,
             "one long output hold-off and one full drain");
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: quaternion_to_compass_heading.f
rtl/core/qch_pkg.sv
rtl/core/qch_in_if.sv
rtl/core/qch_out_if.sv
rtl/core/qch_cordic_stage.sv
rtl/core/quaternion_to_compass_heading.sv
tb/tb_top.sv
